### hw/rtl/ehp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ehp_pkg
// Shared types, constants and helpers for the EBML element header parser.
// ----------------------------------------------------------------------------
package ehp_pkg;

  localparam int OFFSET_W = 48;
  localparam int ID_W     = 32;
  localparam int SIZE_W   = 56;
  localparam int HLEN_W   = 4;
  localparam int STATUS_W = 2;
  localparam int IDLEN_W  = 3;
  localparam int SZLEN_W  = 4;
  localparam int LEFT_W   = 3;

  localparam int IN_TDATA_W  = 200;
  localparam int OUT_TDATA_W = 144;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK          = 2'd0;
  localparam status_t ST_OFFSET_PAST = 2'd1;
  localparam status_t ST_ID_TOO_LONG = 2'd2;
  localparam status_t ST_MISMATCH    = 2'd3;

  localparam logic [7:0] UNKNOWN_SIZE = 8'h7F;

  // Position (1-based, from the top bit) of the first set bit among the top
  // limit bits of a byte; zero when there is none.
  function automatic logic [3:0] marker_pos(input logic [7:0] b, input logic [3:0] limit);
    logic [3:0] pos;
    pos = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (pos == 4'd0 && 4'(i) < limit && b[7-i]) begin
        pos = 4'(i + 1);
      end
    end
    return pos;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/ebml_header_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ebml_header_parser
// Decodes EBML element headers (ID and size) one byte per word.
// A result passes through the input register and then the result register.
// Throughput: one byte per cycle while the receiver takes results, set by the input and result registers.
// Reset clears the control state and file_length; no clearing pass.
// ----------------------------------------------------------------------------
module ebml_header_parser
  import ehp_pkg::*;
#(
  parameter int MAX_ID_BYTES   = 4,
  parameter int MAX_SIZE_BYTES = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [3:0]             cfg_paddr,
  input  wire logic [63:0]            cfg_pwdata,
  output logic      [63:0]            cfg_prdata,
  output logic                        cfg_pready,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // data_byte, element_offset, has_container, container_end, expected_id,
  // expected_total, zero fill.
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // header_start.
  input  wire logic                   in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // element_id, data_size, data_offset, header_length, zero fill.
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // status.
  output logic [STATUS_W-1:0]         out_tuser
);

  localparam logic [1:0] PH_IDLE       = 2'd0;
  localparam logic [1:0] PH_ID         = 2'd1;
  localparam logic [1:0] PH_SIZE_FIRST = 2'd2;
  localparam logic [1:0] PH_SIZE_REST  = 2'd3;

  logic [OFFSET_W-1:0] file_length_r;
  logic [OFFSET_W-1:0] limit_r;
  logic                cfg_wr;

  logic                ib_valid_r;
  logic                ib_start_r;
  logic [7:0]          ib_byte_r;
  logic [OFFSET_W-1:0] ib_offset_r;
  logic                ib_has_cont_r;
  logic [OFFSET_W-1:0] ib_cont_end_r;
  logic [ID_W-1:0]     ib_exp_id_r;
  logic [SIZE_W-1:0]   ib_exp_total_r;

  logic [1:0]          phase_r, phase_nxt;
  logic [ID_W-1:0]     id_accum_r, id_accum_nxt;
  logic [LEFT_W-1:0]   bytes_left_r, bytes_left_nxt;
  logic [SIZE_W-1:0]   size_accum_r, size_accum_nxt;
  logic [IDLEN_W-1:0]  id_len_r, id_len_nxt;
  logic [SZLEN_W-1:0]  size_len_r, size_len_nxt;
  logic [OFFSET_W-1:0] start_offset_r, start_offset_nxt;
  logic [OFFSET_W-1:0] bound_r, bound_nxt;
  logic [ID_W-1:0]     want_id_r, want_id_nxt;
  logic [SIZE_W-1:0]   want_total_r, want_total_nxt;

  logic                proc_ok;
  logic                proc_fire;
  logic                do_emit;
  logic                early;
  status_t             early_status;
  logic [3:0]          id_pos;
  logic [3:0]          sz_pos;

  logic [HLEN_W-1:0]   hl;
  logic [OFFSET_W:0]   used_full;
  logic [OFFSET_W-1:0] used;
  logic                unknown;
  logic [SIZE_W-1:0]   sz;
  logic [SIZE_W:0]     total;
  logic                mismatch;

  logic                out_valid_r;
  logic [ID_W-1:0]     out_id_r;
  logic [SIZE_W-1:0]   out_size_r;
  logic [OFFSET_W-1:0] out_doff_r;
  logic [HLEN_W-1:0]   out_hl_r;
  status_t             out_status_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[3];
  assign cfg_prdata = cfg_paddr[3] ? 64'd0 : 64'(file_length_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_length_r <= '0;
      limit_r       <= '1;
    end else if (cfg_wr) begin
      file_length_r <= cfg_pwdata[OFFSET_W-1:0];
      limit_r       <= cfg_pwdata[OFFSET_W-1:0] - OFFSET_W'(1);
    end
  end

  assign proc_ok   = !out_valid_r || out_tready;
  assign proc_fire = ib_valid_r && proc_ok;
  assign in_tready = !ib_valid_r || proc_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ib_valid_r <= 1'b0;
    end else if (in_tready) begin
      ib_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ib_start_r     <= in_tuser;
      ib_byte_r      <= in_tdata[7:0];
      ib_offset_r    <= in_tdata[55:8];
      ib_has_cont_r  <= in_tdata[56];
      ib_cont_end_r  <= in_tdata[104:57];
      ib_exp_id_r    <= in_tdata[136:105];
      ib_exp_total_r <= in_tdata[192:137];
    end
  end

  assign id_pos = marker_pos(ib_byte_r, 4'(MAX_ID_BYTES));
  assign sz_pos = marker_pos(ib_byte_r, 4'(MAX_SIZE_BYTES));

  always_comb begin
    phase_nxt        = phase_r;
    id_accum_nxt     = id_accum_r;
    bytes_left_nxt   = bytes_left_r;
    size_accum_nxt   = size_accum_r;
    id_len_nxt       = id_len_r;
    size_len_nxt     = size_len_r;
    start_offset_nxt = start_offset_r;
    bound_nxt        = bound_r;
    want_id_nxt      = want_id_r;
    want_total_nxt   = want_total_r;
    do_emit          = 1'b0;
    early            = 1'b0;
    early_status     = ST_OK;
    if (ib_start_r) begin
      start_offset_nxt = ib_offset_r;
      bound_nxt        = ib_has_cont_r ? ib_cont_end_r : file_length_r;
      want_id_nxt      = ib_exp_id_r;
      want_total_nxt   = ib_exp_total_r;
      phase_nxt        = PH_IDLE;
      if (ib_offset_r >= limit_r) begin
        do_emit      = 1'b1;
        early        = 1'b1;
        early_status = ST_OFFSET_PAST;
      end else if (id_pos == 4'd0) begin
        do_emit      = 1'b1;
        early        = 1'b1;
        early_status = ST_ID_TOO_LONG;
      end else begin
        id_accum_nxt = ID_W'(ib_byte_r);
        id_len_nxt   = id_pos[IDLEN_W-1:0];
        if (id_pos == 4'd1) begin
          phase_nxt = PH_SIZE_FIRST;
        end else begin
          bytes_left_nxt = LEFT_W'(id_pos - 4'd1);
          phase_nxt      = PH_ID;
        end
      end
    end else begin
      unique case (phase_r)
        PH_ID: begin
          id_accum_nxt   = {id_accum_r[ID_W-9:0], ib_byte_r};
          bytes_left_nxt = bytes_left_r - LEFT_W'(1);
          if (bytes_left_r == LEFT_W'(1)) begin
            phase_nxt = PH_SIZE_FIRST;
          end
        end
        PH_SIZE_FIRST: begin
          if (sz_pos == 4'd0) begin
            size_len_nxt   = SZLEN_W'(1);
            size_accum_nxt = '0;
            do_emit        = 1'b1;
            phase_nxt      = PH_IDLE;
          end else begin
            size_accum_nxt = SIZE_W'(ib_byte_r & (8'hFF >> sz_pos));
            size_len_nxt   = sz_pos;
            if (sz_pos == 4'd1) begin
              do_emit   = 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              bytes_left_nxt = LEFT_W'(sz_pos - 4'd1);
              phase_nxt      = PH_SIZE_REST;
            end
          end
        end
        PH_SIZE_REST: begin
          size_accum_nxt = {size_accum_r[SIZE_W-9:0], ib_byte_r};
          bytes_left_nxt = bytes_left_r - LEFT_W'(1);
          if (bytes_left_r == LEFT_W'(1)) begin
            do_emit   = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    hl        = HLEN_W'(id_len_r) + size_len_nxt;
    used_full = {1'b0, start_offset_r} + (OFFSET_W + 1)'(hl);
    used      = used_full[OFFSET_W-1:0];
    unknown   = (size_len_nxt == SZLEN_W'(1)) && (size_accum_nxt == SIZE_W'(UNKNOWN_SIZE));
    if (unknown) begin
      sz = ({1'b0, bound_r} > used_full) ? SIZE_W'(bound_r - used) : '0;
    end else begin
      sz = size_accum_nxt;
    end
    total    = {1'b0, sz} + (SIZE_W + 1)'(hl);
    mismatch = (want_id_r != '0 && want_id_r != id_accum_r) ||
               (want_total_r != '0 && {1'b0, want_total_r} != total);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (proc_fire) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      id_accum_r     <= id_accum_nxt;
      bytes_left_r   <= bytes_left_nxt;
      size_accum_r   <= size_accum_nxt;
      id_len_r       <= id_len_nxt;
      size_len_r     <= size_len_nxt;
      start_offset_r <= start_offset_nxt;
      bound_r        <= bound_nxt;
      want_id_r      <= want_id_nxt;
      want_total_r   <= want_total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire && do_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && do_emit) begin
      if (early) begin
        out_id_r     <= '0;
        out_size_r   <= '0;
        out_doff_r   <= '0;
        out_hl_r     <= '0;
        out_status_r <= early_status;
      end else begin
        out_id_r     <= id_accum_r;
        out_size_r   <= sz;
        out_doff_r   <= used;
        out_hl_r     <= hl;
        out_status_r <= mismatch ? ST_MISMATCH : ST_OK;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_hl_r, out_doff_r, out_size_r, out_id_r};
  assign out_tuser  = out_status_r;

  a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ID || phase_r == PH_SIZE_REST) |-> bytes_left_r != '0)
    else $error("header in progress with no bytes left");

  a_id_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_IDLE |-> (id_len_r != '0 && 32'(id_len_r) <= MAX_ID_BYTES))
    else $error("ID length out of range during a header");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && do_emit) |=> out_valid_r)
    else $error("result lost at the output register");

  a_ok_hlen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_OK || out_status_r == ST_MISMATCH))
      |-> out_hl_r >= HLEN_W'(2))
    else $error("decoded header shorter than two bytes");

  a_early_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_OFFSET_PAST || out_status_r == ST_ID_TOO_LONG))
      |-> (out_hl_r == '0 && out_id_r == '0))
    else $error("failed header carries decoded fields");

endmodule
`default_nettype wire

### test/ehp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ehp_checker
// Watches the configuration port and both streams of the EBML header parser.
// It keeps its own decoder of header bytes, queues the header it expects from
// each completed or rejected header, and compares every result word with the
// oldest queued header field by field.
// ----------------------------------------------------------------------------
module ehp_checker
  import ehp_pkg::*;
#(
  parameter logic [3:0] FILE_LENGTH_ADDR = 4'd0
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [3:0]             cfg_paddr,
  input  wire logic [63:0]            cfg_pwdata,
  input  wire logic                   cfg_pready,
  input  wire logic                   in_tvalid,
  input  wire logic                   in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   in_tuser,
  input  wire logic                   out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic [OUT_TDATA_W-1:0] out_tdata,
  input  wire logic [STATUS_W-1:0]    out_tuser,
  output int                          fail_count,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ID_BYTES_MAX   = 4;
  localparam int SIZE_BYTES_MAX = 8;

  typedef enum logic [1:0] {
    HDR_IDLE,
    HDR_ID,
    HDR_SIZE_FIRST,
    HDR_SIZE_REST
  } hdr_phase_t;

  typedef struct {
    logic [ID_W-1:0]     element_id;
    logic [SIZE_W-1:0]   data_size;
    logic [OFFSET_W-1:0] data_offset;
    logic [HLEN_W-1:0]   header_length;
    status_t             status;
  } header_result_t;

  header_result_t      expected_headers[$];
  hdr_phase_t          phase;
  logic [ID_W-1:0]     id_acc;
  logic [3:0]          remaining;
  logic [SIZE_W-1:0]   size_acc;
  logic [2:0]          id_len;
  logic [3:0]          size_len;
  logic [OFFSET_W-1:0] start_off;
  logic [OFFSET_W-1:0] bound;
  logic [ID_W-1:0]     want_id;
  logic [SIZE_W-1:0]   want_total;
  logic [OFFSET_W-1:0] file_len;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic int unsigned marker_length(input logic [7:0] b, input int unsigned max_len);
    int unsigned n;
    n = 1;
    while (n <= max_len && !b[8-n]) n++;
    return n;
  endfunction

  task automatic reject_header(input status_t st);
    header_result_t r;
    r.element_id    = '0;
    r.data_size     = '0;
    r.data_offset   = '0;
    r.header_length = '0;
    r.status        = st;
    expected_headers.push_back(r);
  endtask

  task automatic close_header();
    header_result_t r;
    logic [HLEN_W-1:0] hl;
    logic [63:0] used;
    logic [SIZE_W-1:0] sz;
    logic [SIZE_W:0] total;
    hl = HLEN_W'(id_len) + size_len;
    used = 64'(start_off) + 64'(hl);
    sz = size_acc;
    // An unknown size runs to the bound, never below zero.
    if (size_len == 4'd1 && size_acc == SIZE_W'(UNKNOWN_SIZE)) begin
      sz = (64'(bound) > used) ? SIZE_W'(64'(bound) - used) : '0;
    end
    total = (SIZE_W+1)'(hl) + (SIZE_W+1)'(sz);
    r.element_id    = id_acc;
    r.data_size     = sz;
    r.data_offset   = used[OFFSET_W-1:0];
    r.header_length = hl;
    r.status        = ST_OK;
    if ((want_id != '0 && want_id != id_acc) ||
        (want_total != '0 && (SIZE_W+1)'(want_total) != total)) begin
      r.status = ST_MISMATCH;
    end
    phase = HDR_IDLE;
    expected_headers.push_back(r);
  endtask

  task automatic decode_header_byte(input logic [IN_TDATA_W-1:0] d, input logic start);
    int unsigned n;
    logic [7:0] b;
    logic [7:0] mk;
    b = d[7:0];
    if (start) begin
      start_off  = d[55:8];
      bound      = d[56] ? d[104:57] : file_len;
      want_id    = d[136:105];
      want_total = d[192:137];
      phase      = HDR_IDLE;
      if (start_off >= file_len - 48'd1) begin
        reject_header(ST_OFFSET_PAST);
      end else begin
        n = marker_length(b, ID_BYTES_MAX);
        if (n > ID_BYTES_MAX) begin
          reject_header(ST_ID_TOO_LONG);
        end else begin
          id_acc = ID_W'(b);
          id_len = 3'(n);
          if (n == 1) begin
            phase = HDR_SIZE_FIRST;
          end else begin
            remaining = 4'(n - 1);
            phase = HDR_ID;
          end
        end
      end
    end else begin
      case (phase)
        HDR_ID: begin
          id_acc = {id_acc[ID_W-9:0], b};
          remaining--;
          if (remaining == 4'd0) phase = HDR_SIZE_FIRST;
        end
        HDR_SIZE_FIRST: begin
          n = marker_length(b, SIZE_BYTES_MAX);
          if (n > SIZE_BYTES_MAX) begin
            size_len = 4'd1;
            size_acc = '0;
            close_header();
          end else begin
            mk = 8'h80 >> (n - 1);
            size_acc = SIZE_W'(b & (mk - 8'd1));
            size_len = 4'(n);
            if (n == 1) begin
              close_header();
            end else begin
              remaining = 4'(n - 1);
              phase = HDR_SIZE_REST;
            end
          end
        end
        HDR_SIZE_REST: begin
          size_acc = {size_acc[SIZE_W-9:0], b};
          remaining--;
          if (remaining == 4'd0) close_header();
        end
        default: begin
        end
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch_channels
    header_result_t want;
    if (!rst_n) begin
      expected_headers.delete();
      phase      = HDR_IDLE;
      id_acc     = '0;
      remaining  = '0;
      size_acc   = '0;
      id_len     = '0;
      size_len   = '0;
      start_off  = '0;
      bound      = '0;
      want_id    = '0;
      want_total = '0;
      file_len   = '0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == FILE_LENGTH_ADDR) begin
        file_len = cfg_pwdata[OFFSET_W-1:0];
      end
      if (out_tvalid && out_tready) begin
        if (expected_headers.size() == 0) begin
          $error("result word arrived with no header pending");
          fail_count++;
        end else begin
          want = expected_headers.pop_front();
          check_field("element_id", 64'(want.element_id), 64'(out_tdata[31:0]));
          check_field("data_size", 64'(want.data_size), 64'(out_tdata[87:32]));
          check_field("data_offset", 64'(want.data_offset), 64'(out_tdata[135:88]));
          check_field("header_length", 64'(want.header_length), 64'(out_tdata[139:136]));
          check_field("status", 64'(want.status), 64'(out_tuser));
        end
      end
      if (in_tvalid && in_tready) decode_header_byte(in_tdata, in_tuser);
    end
    pending = expected_headers.size();
  end

endmodule
`default_nettype wire

### test/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Drives the EBML header parser with a short set of hand-picked headers and
// then with random headers under several file lengths, with bursty input and
// a stalling receiver; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
module testbench
  import ehp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] FILE_LENGTH_ADDR = 4'd0;
  localparam logic [47:0] OFFSET_MAX = 48'hFFFF_FFFF_FFFF;
  localparam int PHASE_ITEMS = 125;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_RARE_STALL
  } rx_mode_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [3:0]             cfg_paddr;
  logic [63:0]            cfg_pwdata;
  logic [63:0]            cfg_prdata;
  logic                   cfg_pready;
  logic                   in_tvalid;
  logic                   in_tready;
  // data_byte, element_offset, has_container, container_end, expected_id,
  // expected_total, zero fill.
  logic [IN_TDATA_W-1:0]  in_tdata;
  // header_start.
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // element_id, data_size, data_offset, header_length, zero fill.
  logic [OUT_TDATA_W-1:0] out_tdata;
  // status.
  logic [STATUS_W-1:0]    out_tuser;

  int          fail_count;
  int          pending;
  int          burst_left = 0;
  int unsigned sent_items = 0;
  logic [47:0] file_length_now = '0;
  rx_mode_t    rx_mode = RX_OPEN;
  int          rx_left = 0;

  ebml_header_parser DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  ehp_checker #(
    .FILE_LENGTH_ADDR (FILE_LENGTH_ADDR)
  ) header_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(10, 150);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   out_tready = 1'b1;
      RX_COIN:   out_tready = 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready = ($urandom_range(0, 3) == 0);
      default:   out_tready = ($urandom_range(0, 15) != 0);
    endcase
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  function automatic logic [55:0] rand56();
    return {24'($urandom), $urandom};
  endfunction

  task automatic send_word(input logic [IN_TDATA_W-1:0] data, input logic start);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tdata  = data;
    in_tuser  = start;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic send_start(input logic [7:0] b, input logic [47:0] off, input logic hasc,
                            input logic [47:0] cend, input logic [31:0] eid,
                            input logic [55:0] etot);
    send_word(IN_TDATA_W'({etot, eid, cend, hasc, off, b}), 1'b1);
  endtask

  // Continuation words carry random junk in the fields that only a start word uses.
  task automatic send_byte(input logic [7:0] b);
    send_word(IN_TDATA_W'({rand56(), 32'($urandom), rand48(), 1'($urandom), rand48(), b}),
              1'b0);
  endtask

  task automatic write_file_length(input logic [47:0] value);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = FILE_LENGTH_ADDR;
    cfg_pwdata  = 64'(value);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    file_length_now = value;
  endtask

  task automatic settle();
    in_tvalid = 1'b0;
    wait (pending == 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic send_random_header();
    logic [47:0] limit;
    logic [47:0] off;
    logic [47:0] cend;
    logic [7:0]  id_bytes[4];
    logic [7:0]  size_bytes[8];
    logic [7:0]  mk;
    logic [31:0] id_val;
    logic [31:0] eid;
    logic [55:0] size_val;
    logic [55:0] etot;
    int unsigned id_n;
    int unsigned size_n;
    int unsigned cut;
    int unsigned kind;
    limit = file_length_now - 48'd1;
    case ($urandom_range(0, 11))
      0:       off = limit;
      1:       off = OFFSET_MAX;
      2:       off = '0;
      3:       off = limit - 48'd1;
      default: off = (limit == '0) ? rand48() : rand48() % limit;
    endcase
    case ($urandom_range(0, 3))
      0:       cend = rand48();
      1:       cend = off + 48'($urandom_range(0, 40));
      2:       cend = OFFSET_MAX;
      default: cend = off + 48'($urandom_range(0, 1 << 20));
    endcase
    id_n = ($urandom_range(0, 15) == 0) ? 5 : $urandom_range(1, 4);
    if (id_n > 4) begin
      id_bytes[0] = 8'($urandom_range(0, 15));
    end else begin
      mk = 8'h80 >> (id_n - 1);
      id_bytes[0] = mk | (8'($urandom) & (mk - 8'd1));
    end
    id_val = 32'(id_bytes[0]);
    for (int i = 1; i < 4; i++) id_bytes[i] = 8'($urandom);
    for (int i = 1; i < 4; i++) if (i < id_n) id_val = {id_val[23:0], id_bytes[i]};
    kind = $urandom_range(0, 11);
    if (kind == 0) begin
      size_n = 1;
      size_bytes[0] = 8'hFF;
      size_val = 56'h7F;
    end else if (kind == 1) begin
      size_n = 1;
      size_bytes[0] = 8'h00;
      size_val = '0;
    end else begin
      size_n = $urandom_range(1, 8);
      mk = 8'h80 >> (size_n - 1);
      size_bytes[0] = mk | ((kind == 2 ? 8'hFF : 8'($urandom)) & (mk - 8'd1));
      size_val = 56'(size_bytes[0] & (mk - 8'd1));
      for (int i = 1; i < 8; i++) begin
        size_bytes[i] = (kind == 2) ? 8'hFF : (kind == 3) ? 8'h00 : 8'($urandom);
        if (i < size_n) size_val = {size_val[47:0], size_bytes[i]};
      end
    end
    case ($urandom_range(0, 3))
      0, 1:    eid = '0;
      2:       eid = id_val;
      default: eid = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0, 1:    etot = '0;
      2, 3:    etot = 56'(id_n + size_n) + size_val;
      4:       etot = 56'(id_n + size_n) + size_val + 56'd1;
      default: etot = rand56();
    endcase
    send_start(id_bytes[0], off, 1'($urandom), cend, eid, etot);
    sent_items++;
    if (off >= limit || id_n > 4) return;
    // Now and then a header is cut short so that the next start word restarts it.
    cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, id_n + size_n - 2) : 99;
    for (int i = 1; i < id_n; i++) begin
      if (cut-- == 0) return;
      send_byte(id_bytes[i]);
      sent_items++;
    end
    for (int i = 0; i < size_n; i++) begin
      if (cut-- == 0) return;
      send_byte(size_bytes[i]);
      sent_items++;
    end
  endtask

  initial begin : stimulus
    logic [47:0] lengths[7];
    int unsigned goal;
    rst_n       = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // File length is still zero here, so the offset limit wraps to the top value.
    send_start(8'h81, OFFSET_MAX, 1'b0, '0, '0, '0);
    send_start(8'h0F, '0, 1'b0, '0, '0, '0);
    send_start(8'h00, '0, 1'b1, OFFSET_MAX, '1, '1);
    send_start(8'h81, '0, 1'b0, '0, '0, 56'd2);
    send_byte(8'h80);
    send_start(8'h1A, OFFSET_MAX - 48'd1, 1'b1, OFFSET_MAX, 32'h1A45_DFA3, '1);
    send_byte(8'h45);
    send_byte(8'hDF);
    send_byte(8'hA3);
    send_byte(8'h01);
    repeat (7) send_byte(8'hFF);
    send_start(8'h86, 48'd100, 1'b1, OFFSET_MAX, '0, '0);
    send_byte(8'hFF);
    send_start(8'hEC, 48'd10, 1'b0, 48'd5, '0, '0);
    send_byte(8'hFF);
    send_start(8'h80, 48'd5, 1'b0, '0, '0, 56'd2);
    send_byte(8'h00);
    send_start(8'h42, 48'd7, 1'b0, '0, 32'h4287, '0);
    send_byte(8'h86);
    send_byte(8'h81);
    send_byte(8'h55);
    send_start(8'h1A, '0, 1'b0, '0, '0, '0);
    send_byte(8'h45);
    send_start(8'hEC, 48'd1, 1'b0, '0, '0, '0);
    send_byte(8'h81);

    lengths = '{OFFSET_MAX, 48'd1, 48'd2, 48'd5000, rand48(), 48'd0, 48'd300};
    foreach (lengths[k]) begin
      settle();
      write_file_length(lengths[k]);
      goal = sent_items + PHASE_ITEMS;
      while (sent_items < goal) begin
        if ($urandom_range(0, 14) == 0) begin
          if ($urandom_range(0, 1) == 1) begin
            send_start(8'($urandom), rand48(), 1'($urandom), rand48(), $urandom, rand56());
          end else begin
            send_byte(8'($urandom));
          end
        end else begin
          send_random_header();
        end
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
